/* hdl/mlr_pkg.sv */
package mlr_pkg;

   localparam int COORD_BITS     = 12;
   localparam int NORM_BITS      = COORD_BITS + 1;
   localparam int ERR_BITS       = COORD_BITS + 3;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [NORM_BITS-1:0]  norm_type;
   typedef logic signed [ERR_BITS-1:0]   err_type;

   typedef struct packed {
      logic     op;
      logic     mirror;
      logic     swap;
      norm_type ax;
      norm_type ay;
      norm_type bx;
      norm_type by;
   } cmd_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } pixel_type;

   function automatic err_type widen_norm(norm_type v);
      return {{(ERR_BITS-NORM_BITS){v[NORM_BITS-1]}}, v};
   endfunction

   function automatic pixel_type map_pixel(logic swap, logic mirror, norm_type x, norm_type y);
      norm_type  sx;
      norm_type  sy;
      pixel_type p;
      sx = swap ? y : x;
      sy = swap ? x : y;
      if (mirror) begin
         sy = -sy;
      end
      p.x = sx[COORD_BITS-1:0];
      p.y = sy[COORD_BITS-1:0];
      return p;
   endfunction

endpackage

/* hdl/mlr_front.sv */
module mlr_front (
   input  logic                req_op,
   input  mlr_pkg::coord_type  req_x_start,
   input  mlr_pkg::coord_type  req_y_start,
   input  mlr_pkg::coord_type  req_x_end,
   input  mlr_pkg::coord_type  req_y_end,
   output mlr_pkg::cmd_type    cmd
);
   import mlr_pkg::*;

   norm_type ax, ay, bx, by;
   norm_type diff_x, diff_y, mag_x, mag_y;
   norm_type may, mby;
   norm_type nax, nay, nbx, nby;
   logic     mirror, swap;

   always_comb begin
      ax = {req_x_start[COORD_BITS-1], req_x_start};
      ay = {req_y_start[COORD_BITS-1], req_y_start};
      bx = {req_x_end[COORD_BITS-1], req_x_end};
      by = {req_y_end[COORD_BITS-1], req_y_end};

      diff_x = ax - bx;
      diff_y = ay - by;
      mag_x  = diff_x[NORM_BITS-1] ? -diff_x : diff_x;
      mag_y  = diff_y[NORM_BITS-1] ? -diff_y : diff_y;
      swap   = $unsigned(mag_x) < $unsigned(mag_y);

      // endpoint with the lower y (ties keep input order) must not lie to the right
      mirror = (ay > by) ? (bx > ax) : (ax > bx);

      may = mirror ? -ay : ay;
      mby = mirror ? -by : by;

      nax = swap ? may : ax;
      nay = swap ? ax  : may;
      nbx = swap ? mby : bx;
      nby = swap ? bx  : mby;

      cmd.op     = req_op;
      cmd.mirror = mirror;
      cmd.swap   = swap;
      if (nax > nbx) begin
         cmd.ax = nbx;
         cmd.ay = nby;
         cmd.bx = nax;
         cmd.by = nay;
      end else begin
         cmd.ax = nax;
         cmd.ay = nay;
         cmd.bx = nbx;
         cmd.by = nby;
      end
   end

endmodule

/* hdl/mlr_queue.sv */
module mlr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mlr_pkg::cmd_type  push_data,
   output logic              full,
   input  logic              pop,
   output mlr_pkg::cmd_type  pop_data,
   output logic              empty
);
   import mlr_pkg::*;

   cmd_type                   entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push, do_pop;

   assign full     = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hdl/mlr_back.sv */
module mlr_back (
   input  logic                clock,
   input  logic                reset,
   input  mlr_pkg::cmd_type    cmd,
   input  logic                cmd_empty,
   output logic                cmd_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output mlr_pkg::coord_type  rsp_pixel_x,
   output mlr_pkg::coord_type  rsp_pixel_y,
   output logic                rsp_last
);
   import mlr_pkg::*;

   logic      mirror_ff, mirror_in;
   logic      swap_ff, swap_in;
   logic      active_ff, active_in;
   norm_type  cur_x_ff, cur_x_in;
   norm_type  cur_y_ff, cur_y_in;
   norm_type  end_x_ff, end_x_in;
   err_type   err_ff, err_in;
   err_type   inc_e_ff, inc_e_in;
   err_type   inc_ne_ff, inc_ne_in;
   logic      rsp_valid_ff, rsp_valid_in;
   pixel_type rsp_pixel_ff, rsp_pixel_in;
   logic      rsp_last_ff, rsp_last_in;

   logic      out_free, take, produce, go_ne;
   err_type   dx, dy;
   norm_type  step_x, step_y;

   assign out_free    = !rsp_valid_ff || rsp_pop;
   assign take        = !cmd_empty && out_free;
   assign cmd_pop     = take;
   assign rsp_empty   = !rsp_valid_ff;
   assign rsp_pixel_x = rsp_pixel_ff.x;
   assign rsp_pixel_y = rsp_pixel_ff.y;
   assign rsp_last    = rsp_last_ff;

   always_comb begin
      dx     = widen_norm(cmd.bx) - widen_norm(cmd.ax);
      dy     = widen_norm(cmd.by) - widen_norm(cmd.ay);
      go_ne  = !err_ff[ERR_BITS-1] && (err_ff != '0);
      step_x = cur_x_ff + 1'b1;
      step_y = go_ne ? cur_y_ff + 1'b1 : cur_y_ff;

      mirror_in    = mirror_ff;
      swap_in      = swap_ff;
      active_in    = active_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      end_x_in     = end_x_ff;
      err_in       = err_ff;
      inc_e_in     = inc_e_ff;
      inc_ne_in    = inc_ne_ff;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_last_in  = rsp_last_ff;
      produce      = 1'b0;

      if (take) begin
         if (cmd.op == OP_START) begin
            produce      = 1'b1;
            mirror_in    = cmd.mirror;
            swap_in      = cmd.swap;
            cur_x_in     = cmd.ax;
            cur_y_in     = cmd.ay;
            end_x_in     = cmd.bx;
            err_in       = (dy <<< 1) - dx;
            inc_e_in     = dy <<< 1;
            inc_ne_in    = (dy - dx) <<< 1;
            active_in    = cmd.ax < cmd.bx;
            rsp_pixel_in = map_pixel(cmd.swap, cmd.mirror, cmd.ax, cmd.ay);
            rsp_last_in  = !(cmd.ax < cmd.bx);
         end else if (active_ff) begin
            produce      = 1'b1;
            err_in       = go_ne ? err_ff + inc_ne_ff : err_ff + inc_e_ff;
            cur_x_in     = step_x;
            cur_y_in     = step_y;
            active_in    = step_x < end_x_ff;
            rsp_pixel_in = map_pixel(swap_ff, mirror_ff, step_x, step_y);
            rsp_last_in  = !(step_x < end_x_ff);
         end
      end

      if (produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mirror_ff    <= 1'b0;
         swap_ff      <= 1'b0;
         active_ff    <= 1'b0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         end_x_ff     <= '0;
         err_ff       <= '0;
         inc_e_ff     <= '0;
         inc_ne_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mirror_ff    <= mirror_in;
         swap_ff      <= swap_in;
         active_ff    <= active_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         end_x_ff     <= end_x_in;
         err_ff       <= err_in;
         inc_e_ff     <= inc_e_in;
         inc_ne_ff    <= inc_ne_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/midpoint_line_rasterizer.sv */
// Midpoint line rasterizer for all octants. A start transaction (op 0) carries two
// signed endpoints and returns the first pixel; each step transaction (op 1) returns
// the next pixel, with last set on the final endpoint. A step with no line in
// progress returns nothing. One transaction is accepted per clock while the queue
// is not full, and one pixel is produced per clock while the result register is
// empty or being popped: the front end folds the endpoints into the first octant
// in the cycle of the push, a two-entry command queue follows, and the stepping
// unit advances the error term by one add and compare per clock. A pixel passes
// through the command queue and then the result register before it reaches the
// result ports; the result register frees up in the same cycle it is popped.
module midpoint_line_rasterizer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_op,
   input  mlr_pkg::coord_type  req_x_start,
   input  mlr_pkg::coord_type  req_y_start,
   input  mlr_pkg::coord_type  req_x_end,
   input  mlr_pkg::coord_type  req_y_end,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output mlr_pkg::coord_type  rsp_pixel_x,
   output mlr_pkg::coord_type  rsp_pixel_y,
   output logic                rsp_last
);
   import mlr_pkg::*;

   cmd_type front_cmd;
   cmd_type queue_cmd;
   logic    queue_empty;
   logic    queue_pop;

   mlr_front u_front (
      .req_op      (req_op),
      .req_x_start (req_x_start),
      .req_y_start (req_y_start),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .cmd         (front_cmd)
   );

   mlr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_cmd),
      .full      (req_full),
      .pop       (queue_pop),
      .pop_data  (queue_cmd),
      .empty     (queue_empty)
   );

   mlr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd         (queue_cmd),
      .cmd_empty   (queue_empty),
      .cmd_pop     (queue_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_pixel_x (rsp_pixel_x),
      .rsp_pixel_y (rsp_pixel_y),
      .rsp_last    (rsp_last)
   );

endmodule

/* bench/line_pixel_checker.sv */
module line_pixel_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_full,
   input  logic               req_op,
   input  mlr_pkg::coord_type req_x_start,
   input  mlr_pkg::coord_type req_y_start,
   input  mlr_pkg::coord_type req_x_end,
   input  mlr_pkg::coord_type req_y_end,
   input  logic               rsp_empty,
   input  logic               rsp_pop,
   input  mlr_pkg::coord_type rsp_pixel_x,
   input  mlr_pkg::coord_type rsp_pixel_y,
   input  logic               rsp_last,
   output int                 mismatches,
   output int                 waiting,
   output int                 checked
);
   import mlr_pkg::*;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      last;
   } pixel_rec_type;

   pixel_rec_type pending_pixels[$];

   logic     mirror_q;
   logic     swap_q;
   logic     drawing;
   norm_type pos_x;
   norm_type pos_y;
   norm_type stop_x;
   err_type  err_acc;
   err_type  step_e;
   err_type  step_ne;

   function automatic pixel_rec_type screen_pixel(logic fin);
      int            sx;
      int            sy;
      pixel_rec_type p;
      sx = swap_q ? int'(pos_y) : int'(pos_x);
      sy = swap_q ? int'(pos_x) : int'(pos_y);
      if (mirror_q) begin
         sy = -sy;
      end
      p.x    = coord_type'(sx);
      p.y    = coord_type'(sy);
      p.last = fin;
      return p;
   endfunction

   task automatic begin_line(coord_type xs, coord_type ys, coord_type xe, coord_type ye);
      int ax;
      int ay;
      int bx;
      int by;
      int lx;
      int ly;
      int hx;
      int hy;
      int t;
      int dx;
      int dy;
      ax = int'(xs);
      ay = int'(ys);
      bx = int'(xe);
      by = int'(ye);
      lx = ax;
      ly = ay;
      hx = bx;
      hy = by;
      if (ly > hy) begin
         lx = bx;
         ly = by;
         hx = ax;
         hy = ay;
      end
      mirror_q = lx > hx;
      swap_q   = ((ax > bx) ? ax - bx : bx - ax) < ((ay > by) ? ay - by : by - ay);
      if (mirror_q) begin
         ay = -ay;
         by = -by;
      end
      if (swap_q) begin
         t = ax; ax = ay; ay = t;
         t = bx; bx = by; by = t;
      end
      if (ax > bx) begin
         t = ax; ax = bx; bx = t;
         t = ay; ay = by; by = t;
      end
      dx      = bx - ax;
      dy      = by - ay;
      err_acc = err_type'(2 * dy - dx);
      step_e  = err_type'(2 * dy);
      step_ne = err_type'(2 * (dy - dx));
      pos_x   = norm_type'(ax);
      pos_y   = norm_type'(ay);
      stop_x  = norm_type'(bx);
      drawing = pos_x < stop_x;
      pending_pixels.push_back(screen_pixel(!drawing));
   endtask

   task automatic advance_line();
      if (!drawing) begin
         return;
      end
      if (err_acc <= 0) begin
         err_acc = err_acc + step_e;
      end else begin
         err_acc = err_acc + step_ne;
         pos_y   = norm_type'(pos_y + 1);
      end
      pos_x   = norm_type'(pos_x + 1);
      drawing = pos_x < stop_x;
      pending_pixels.push_back(screen_pixel(!drawing));
   endtask

   always @(posedge clock) begin
      pixel_rec_type want;
      pixel_rec_type got;
      if (reset) begin
         mirror_q   = 1'b0;
         swap_q     = 1'b0;
         drawing    = 1'b0;
         pos_x      = '0;
         pos_y      = '0;
         stop_x     = '0;
         err_acc    = '0;
         step_e     = '0;
         step_ne    = '0;
         mismatches = 0;
         checked    = 0;
         pending_pixels.delete();
      end else begin
         if (!rsp_empty && rsp_pop) begin
            got = '{rsp_pixel_x, rsp_pixel_y, rsp_last};
            if (pending_pixels.size() == 0) begin
               $display("%0t: pixel (%0d,%0d) last %0b with none expected",
                        $time, got.x, got.y, got.last);
               mismatches++;
            end else begin
               want = pending_pixels.pop_front();
               checked++;
               if (got !== want) begin
                  $display("%0t: expected (%0d,%0d) last %0b, got (%0d,%0d) last %0b",
                           $time, want.x, want.y, want.last, got.x, got.y, got.last);
                  mismatches++;
               end
            end
         end
         if (req_push && !req_full) begin
            if (req_op == OP_START) begin
               begin_line(req_x_start, req_y_start, req_x_end, req_y_end);
            end else begin
               advance_line();
            end
         end
      end
      waiting = pending_pixels.size();
   end

endmodule

/* bench/tb_midpoint_line_rasterizer.sv */
module tb_midpoint_line_rasterizer;
   import mlr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 375;

   logic      clock       = 1'b0;
   logic      reset       = 1'b1;
   logic      req_push    = 1'b0;
   logic      req_full;
   logic      req_op      = OP_START;
   coord_type req_x_start = '0;
   coord_type req_y_start = '0;
   coord_type req_x_end   = '0;
   coord_type req_y_end   = '0;
   logic      rsp_empty;
   logic      rsp_pop     = 1'b0;
   coord_type rsp_pixel_x;
   coord_type rsp_pixel_y;
   logic      rsp_last;

   int   mismatches;
   int   waiting;
   int   checked;
   int   cycles      = 0;
   int   send_idle   = 0;
   int   recv_stall  = 0;
   int   hold_off    = 0;
   logic hold_req    = 1'b0;
   logic hold_taken  = 1'b0;
   int   starts_sent = 0;
   int   steps_sent  = 0;

   midpoint_line_rasterizer dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_op      (req_op),
      .req_x_start (req_x_start),
      .req_y_start (req_y_start),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_pixel_x (rsp_pixel_x),
      .rsp_pixel_y (rsp_pixel_y),
      .rsp_last    (rsp_last)
   );

   line_pixel_checker pixel_check (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_op      (req_op),
      .req_x_start (req_x_start),
      .req_y_start (req_y_start),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_pixel_x (rsp_pixel_x),
      .rsp_pixel_y (rsp_pixel_y),
      .rsp_last    (rsp_last),
      .mismatches  (mismatches),
      .waiting     (waiting),
      .checked     (checked)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_req && !hold_taken) begin
         rsp_pop    <= 1'b0;
         hold_taken = 1'b1;
         hold_off   = 79;
      end else if (hold_off > 0) begin
         rsp_pop  <= 1'b0;
         hold_off = hold_off - 1;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_stall);
      end
   end

   task automatic offer(logic op, coord_type xs, coord_type ys, coord_type xe, coord_type ye);
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_op      <= op;
      req_x_start <= xs;
      req_y_start <= ys;
      req_x_end   <= xe;
      req_y_end   <= ye;
      do @(posedge clock); while (req_full);
      if (op == OP_START) starts_sent++;
      else steps_sent++;
   endtask

   task automatic step_noise();
      offer(OP_STEP, coord_type'($urandom), coord_type'($urandom),
            coord_type'($urandom), coord_type'($urandom));
   endtask

   task automatic send_line(int xs, int ys, int xe, int ye, int steps);
      offer(OP_START, coord_type'(xs), coord_type'(ys), coord_type'(xe), coord_type'(ye));
      repeat (steps) step_noise();
   endtask

   function automatic int pick_end(int a, int d);
      int b;
      b = a + d;
      if (b > 2047 || b < -2048) begin
         b = a - d;
      end
      return b;
   endfunction

   function automatic int span_of(int xs, int ys, int xe, int ye);
      int adx;
      int ady;
      adx = (xs > xe) ? xs - xe : xe - xs;
      ady = (ys > ye) ? ys - ye : ye - ys;
      return (adx > ady) ? adx : ady;
   endfunction

   task automatic random_lines(int budget);
      int used;
      int kind;
      int xs;
      int ys;
      int xe;
      int ye;
      int reach;
      int span;
      int steps;
      used = 0;
      while (used < budget) begin
         kind = int'($urandom_range(99));
         if (kind < 5) begin
            step_noise();
            used += 1;
         end else begin
            xs = int'(coord_type'($urandom));
            ys = int'(coord_type'($urandom));
            if (kind < 12) begin
               xe = int'(coord_type'($urandom));
               ye = int'(coord_type'($urandom));
            end else begin
               reach = (kind < 15) ? 400 : 12;
               xe = pick_end(xs, int'($urandom_range(2 * reach)) - reach);
               ye = pick_end(ys, int'($urandom_range(2 * reach)) - reach);
            end
            span = span_of(xs, ys, xe, ye);
            if (kind < 12) begin
               steps = int'($urandom_range(8));
            end else if ($urandom_range(9) == 0) begin
               steps = int'($urandom_range(span));
            end else begin
               steps = span + int'($urandom_range(2));
            end
            send_line(xs, ys, xe, ye, steps);
            used += 1 + steps;
         end
      end
   endtask

   initial begin
      int idle_of [4];
      int stall_of [4];
      idle_of  = '{0, 69, 0, 13};
      stall_of = '{0, 0, 69, 13};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      step_noise();
      send_line(0, 0, 0, 0, 1);
      send_line(-2048, 2047, 2047, -2048, 2);
      send_line(2047, -2048, -2048, -2048, 1);
      send_line(-2048, -2048, -2048, 2047, 1);
      send_line(2047, 2047, -2048, -2048, 1);
      send_line(5, 3, 1, 3, 5);
      send_line(0, 0, -2, 5, 5);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle  = idle_of[ph];
         recv_stall = stall_of[ph];
         if (ph == 0) begin
            hold_req = 1'b1;
         end
         random_lines(PHASE_ITEMS);
      end

      req_push   <= 1'b0;
      recv_stall = 0;
      while (waiting != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d line starts and %0d step transactions over four idle/stall phases",
               starts_sent, steps_sent);
      $display("%0d pixels compared, %0d mismatches", checked, mismatches);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/mlr_pkg.sv
hdl/mlr_front.sv
hdl/mlr_queue.sv
hdl/mlr_back.sv
hdl/midpoint_line_rasterizer.sv
bench/line_pixel_checker.sv
bench/tb_midpoint_line_rasterizer.sv
